// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the relay traffic rate monitor RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rtrm assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("rtrm forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/rtrm_pkg.sv =====
// Package for the relay traffic rate monitor: command codes, controller
// states, divider sizing and the controller/datapath command structs.
package rtrm_pkg;

	// Event codes; codes 5..7 carry no meaning and change nothing
	typedef enum logic [2:0] {
		CMD_FORWARD = 3'd0,
		CMD_FAILURE = 3'd1,
		CMD_SET_UDP = 3'd2,
		CMD_SET_TCP = 3'd3,
		CMD_SAMPLE  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

	localparam int unsigned CNT_W    = 32;
	localparam int unsigned RATE_W   = 16;
	localparam int unsigned SCALE_W  = 14;
	localparam int unsigned DVD_W    = CNT_W + SCALE_W;
	localparam int unsigned STEP_W   = $clog2(DVD_W);

	localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(10000);
	localparam logic [RATE_W-1:0]  RATE_MAX   = 16'hFFFF;
	localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(DVD_W - 1);

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic apply;
		logic mul_load;
		logic div_step;
		logic finish;
		logic load_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sample_go;
	} dp_status_t;

endpackage

// ===== hw/rtl/rtrm_if.sv =====
// Valid/ready channel interfaces for the relay traffic rate monitor:
// one for event items, one for statistics snapshot items. No dependencies.
interface rtrm_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic               toward_car;
	logic signed [31:0] error_code;
	logic [31:0]        time_ms;
	logic [7:0]         slots_used;

	modport source (output valid, command, toward_car, error_code, time_ms, slots_used,
		input ready);
	modport sink (input valid, command, toward_car, error_code, time_ms, slots_used,
		output ready);
endinterface

interface rtrm_out_if;
	logic               valid;
	logic               ready;
	logic [31:0]        packets_to_car;
	logic [31:0]        packets_to_phone;
	logic [15:0]        rate_to_car;
	logic [15:0]        rate_to_phone;
	logic signed [31:0] last_error;
	logic [31:0]        error_run;
	logic [31:0]        last_failure_ms;
	logic [7:0]         udp_in_use;
	logic [7:0]         tcp_in_use;

	modport source (output valid, packets_to_car, packets_to_phone, rate_to_car,
		rate_to_phone, last_error, error_run, last_failure_ms, udp_in_use, tcp_in_use,
		input ready);
	modport sink (input valid, packets_to_car, packets_to_phone, rate_to_car,
		rate_to_phone, last_error, error_run, last_failure_ms, udp_in_use, tcp_in_use,
		output ready);
endinterface

// ===== hw/rtl/relay_traffic_rate_monitor.sv =====
// Relay traffic rate monitor.
// Event items enter on evt (valid/ready); each one returns exactly one
// statistics snapshot item on stats, taken after the event is applied.
// Events: count a forwarded packet, record a failure (run count per error
// code), set UDP/TCP slot usage, or sample both direction rates as
// delta*10000/elapsed time in ms, saturated to 65535.
// Sequence: an item is captured, applied in the next cycle, and its snapshot
// is then registered, which raises stats.valid. A sample with nonzero
// elapsed time adds a multiply step, the bit-serial restoring divider over
// the 46-bit dividend (one quotient bit per cycle, both directions in
// parallel) and a commit step before the snapshot is registered.
// One item is in flight at a time. While a snapshot waits on stats.ready,
// the next event is accepted only in the cycle the snapshot is taken.
// Reset (arst_n low) clears all counters, marks, rates, error and slot
// state to zero and drops any pending snapshot.
// Depends on rtrm_pkg, rtrm_if.sv, rtrm_ctrl and rtrm_dp.
module relay_traffic_rate_monitor
	import rtrm_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	rtrm_in_if.sink  evt,
	rtrm_out_if.source stats
);

	dp_cmd_t    cmd;
	dp_status_t status;

	rtrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (evt.valid),
		.in_ready  (evt.ready),
		.out_valid (stats.valid),
		.out_ready (stats.ready),
		.status    (status),
		.cmd       (cmd)
	);

	rtrm_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.command          (evt.command),
		.toward_car       (evt.toward_car),
		.error_code       (evt.error_code),
		.time_ms          (evt.time_ms),
		.slots_used       (evt.slots_used),
		.packets_to_car   (stats.packets_to_car),
		.packets_to_phone (stats.packets_to_phone),
		.rate_to_car      (stats.rate_to_car),
		.rate_to_phone    (stats.rate_to_phone),
		.last_error       (stats.last_error),
		.error_run        (stats.error_run),
		.last_failure_ms  (stats.last_failure_ms),
		.udp_in_use       (stats.udp_in_use),
		.tcp_in_use       (stats.tcp_in_use)
	);

endmodule

// ===== hw/rtl/rtrm_ctrl.sv =====
// Controller for the relay traffic rate monitor: sequences capture, update,
// the serial rate division and result hand-off. Uses rtrm_pkg, assert_macros.svh.
`include "assert_macros.svh"

module rtrm_ctrl
	import rtrm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              in_fire;

	// Take a new item only when idle and the result slot is free or draining
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_fire) state_d = ST_APPLY;
			ST_APPLY: state_d = status.sample_go ? ST_MUL : ST_EMIT;
			ST_MUL:   state_d = ST_DIV;
			ST_DIV:   if (step_q == LAST_STEP) state_d = ST_FIN;
			ST_FIN:   state_d = ST_EMIT;
			ST_EMIT:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd          = '0;
		cmd.capture  = in_fire;
		cmd.apply    = (state_q == ST_APPLY);
		cmd.mul_load = (state_q == ST_MUL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_FIN);
		cmd.load_out = (state_q == ST_EMIT);
	end

	// State, division step count, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV)
				step_q <= step_q + 1'b1;
			else
				step_q <= '0;
			if (state_q == ST_EMIT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// A new result never lands on one still waiting
	`ASSERT_NEVER(a_emit_free, clk, arst_n, (state_q == ST_EMIT) && out_valid_q)
	`ASSERT_ALWAYS(a_emit_valid, clk, arst_n, (state_q == ST_EMIT) |=> out_valid_q)
	`ASSERT_ALWAYS(a_div_start, clk, arst_n,
		(state_q == ST_MUL) |=> ((state_q == ST_DIV) && (step_q == '0)))
	`ASSERT_ALWAYS(a_div_len, clk, arst_n,
		((state_q == ST_DIV) && (step_q != LAST_STEP)) |=> (state_q == ST_DIV))

endmodule

// ===== hw/rtl/rtrm_dp.sv =====
// Datapath for the relay traffic rate monitor: statistics registers, the
// scale multiply, two restoring divider lanes and the result register. Uses rtrm_pkg.
module rtrm_dp
	import rtrm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	input  logic [2:0]         command,
	input  logic               toward_car,
	input  logic signed [31:0] error_code,
	input  logic [31:0]        time_ms,
	input  logic [7:0]         slots_used,
	output logic [31:0]        packets_to_car,
	output logic [31:0]        packets_to_phone,
	output logic [15:0]        rate_to_car,
	output logic [15:0]        rate_to_phone,
	output logic signed [31:0] last_error,
	output logic [31:0]        error_run,
	output logic [31:0]        last_failure_ms,
	output logic [7:0]         udp_in_use,
	output logic [7:0]         tcp_in_use
);

	// Captured item
	logic [2:0]       cmd_q;
	logic             car_q;
	logic [31:0]      err_q;
	logic [31:0]      time_q;
	logic [7:0]       slots_q;

	// Statistics state
	logic [CNT_W-1:0]  car_total_q, phone_total_q, car_mark_q, phone_mark_q;
	logic [31:0]       mark_time_q, error_last_q, error_count_q, failure_time_q;
	logic [RATE_W-1:0] car_rate_q, phone_rate_q;
	logic [7:0]        udp_q, tcp_q;

	// Divider lanes: dividend shifts out MSB first, quotient shifts in
	logic [DVD_W-1:0] car_dvd_q, phone_dvd_q;
	logic [CNT_W-1:0] car_rem_q, phone_rem_q, divisor_q;

	logic [31:0]      elapsed;
	logic [CNT_W-1:0] car_delta, phone_delta;
	logic [CNT_W:0]   car_sh, phone_sh, car_diff, phone_diff;
	logic             car_ge, phone_ge;

	assign elapsed = time_q - mark_time_q;
	assign status.sample_go = (cmd_q == CMD_SAMPLE) && (elapsed != '0);

	// Packets since the last sample, wrapping at the counter width
	assign car_delta   = car_total_q - car_mark_q;
	assign phone_delta = phone_total_q - phone_mark_q;

	// One restoring step per lane, shared divisor
	assign car_sh     = {car_rem_q, car_dvd_q[DVD_W-1]};
	assign phone_sh   = {phone_rem_q, phone_dvd_q[DVD_W-1]};
	assign car_diff   = car_sh - {1'b0, divisor_q};
	assign phone_diff = phone_sh - {1'b0, divisor_q};
	assign car_ge     = car_sh >= {1'b0, divisor_q};
	assign phone_ge   = phone_sh >= {1'b0, divisor_q};

	function automatic logic [RATE_W-1:0] sat_rate(input logic [DVD_W-1:0] q);
		logic [RATE_W-1:0] r;
		r = (|q[DVD_W-1:RATE_W]) ? RATE_MAX : q[RATE_W-1:0];
		return r;
	endfunction

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= command;
			car_q   <= toward_car;
			err_q   <= error_code;
			time_q  <= time_ms;
			slots_q <= slots_used;
		end
	end

	// Statistics updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_total_q    <= '0;
			phone_total_q  <= '0;
			car_mark_q     <= '0;
			phone_mark_q   <= '0;
			mark_time_q    <= '0;
			car_rate_q     <= '0;
			phone_rate_q   <= '0;
			error_last_q   <= '0;
			error_count_q  <= '0;
			failure_time_q <= '0;
			udp_q          <= '0;
			tcp_q          <= '0;
		end else begin
			if (cmd.apply) begin
				unique case (cmd_q)
					CMD_FORWARD: begin
						if (car_q)
							car_total_q <= car_total_q + 1'b1;
						else
							phone_total_q <= phone_total_q + 1'b1;
					end
					CMD_FAILURE: begin
						if (err_q == error_last_q) begin
							error_count_q <= error_count_q + 1'b1;
						end else begin
							error_last_q  <= err_q;
							error_count_q <= 32'd1;
						end
						failure_time_q <= time_q;
					end
					CMD_SET_UDP: udp_q <= slots_q;
					CMD_SET_TCP: tcp_q <= slots_q;
					default: ;
				endcase
			end
			if (cmd.finish) begin
				car_rate_q   <= sat_rate(car_dvd_q);
				phone_rate_q <= sat_rate(phone_dvd_q);
				car_mark_q   <= car_total_q;
				phone_mark_q <= phone_total_q;
				mark_time_q  <= time_q;
			end
		end
	end

	// Scale multiply, then serial division
	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			car_dvd_q   <= DVD_W'(car_delta) * DVD_W'(RATE_SCALE);
			phone_dvd_q <= DVD_W'(phone_delta) * DVD_W'(RATE_SCALE);
			car_rem_q   <= '0;
			phone_rem_q <= '0;
			divisor_q   <= elapsed;
		end else if (cmd.div_step) begin
			car_rem_q   <= car_ge ? car_diff[CNT_W-1:0] : car_sh[CNT_W-1:0];
			phone_rem_q <= phone_ge ? phone_diff[CNT_W-1:0] : phone_sh[CNT_W-1:0];
			car_dvd_q   <= {car_dvd_q[DVD_W-2:0], car_ge};
			phone_dvd_q <= {phone_dvd_q[DVD_W-2:0], phone_ge};
		end
	end

	// Result snapshot register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			packets_to_car   <= car_total_q;
			packets_to_phone <= phone_total_q;
			rate_to_car      <= car_rate_q;
			rate_to_phone    <= phone_rate_q;
			last_error       <= error_last_q;
			error_run        <= error_count_q;
			last_failure_ms  <= failure_time_q;
			udp_in_use       <= udp_q;
			tcp_in_use       <= tcp_q;
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for relay_traffic_rate_monitor: a directed event table, then random
// event traffic; each snapshot is checked against the table or a behavioral copy of the meter.
// Depends on rtrm_pkg, the rtrm_in_if / rtrm_out_if interfaces and the RTL top level.
module tb;
	import rtrm_pkg::*;

	localparam int unsigned RANDOM_EVENTS = 1750;
	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned HOLD_AT       = 700;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned DRAIN_CYCLES  = 64;
	localparam int unsigned MAX_REPORTS   = 10;
	localparam int unsigned STEADY_FIRST  = 1100;
	localparam int unsigned STEADY_LAST   = 1300;

	// Command codes with no meaning; the block must leave its state alone
	localparam logic [2:0] CMD_SPARE5 = 3'd5;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	typedef struct {
		logic [2:0]         command;
		logic               toward_car;
		logic signed [31:0] error_code;
		logic [31:0]        time_ms;
		logic [7:0]         slots_used;
	} event_t;

	typedef struct {
		logic [31:0]        packets_to_car;
		logic [31:0]        packets_to_phone;
		logic [15:0]        rate_to_car;
		logic [15:0]        rate_to_phone;
		logic signed [31:0] last_error;
		logic [31:0]        error_run;
		logic [31:0]        last_failure_ms;
		logic [7:0]         udp_in_use;
		logic [7:0]         tcp_in_use;
	} snapshot_t;

	// Internal state of the meter as seen from outside
	typedef struct {
		logic [31:0]        car_total;
		logic [31:0]        phone_total;
		logic [31:0]        car_mark;
		logic [31:0]        phone_mark;
		logic [31:0]        mark_ms;
		logic [15:0]        car_rate;
		logic [15:0]        phone_rate;
		logic signed [31:0] err_code;
		logic [31:0]        err_run;
		logic [31:0]        fail_ms;
		logic [7:0]         udp;
		logic [7:0]         tcp;
	} meter_t;

	typedef struct {
		event_t    ev;
		bit        typed;
		snapshot_t snap;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rtrm_in_if  evt_if ();
	rtrm_out_if stats_if ();

	relay_traffic_rate_monitor DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_if),
		.stats  (stats_if)
	);

	meter_t      meter;
	snapshot_t   pending_snaps[$];
	int unsigned mismatches;
	int unsigned snaps_checked;
	int unsigned accepted_events;
	int unsigned sample_events;
	int unsigned idle_samples;
	int unsigned failure_events;
	int unsigned burst_left;
	int unsigned cycle_cnt;
	bit          hold_seen;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Packets per second times ten, saturated
	function automatic logic [15:0] pps_tenths(logic [31:0] delta, logic [31:0] elapsed);
		logic [63:0] q;
		q = (64'(delta) * 64'(RATE_SCALE)) / 64'(elapsed);
		return (q > 64'(RATE_MAX)) ? RATE_MAX : q[15:0];
	endfunction

	// Apply one event to the meter copy and return the snapshot it produces
	function automatic snapshot_t meter_step(inout meter_t m, input event_t ev);
		logic [31:0] elapsed;
		snapshot_t s;
		case (ev.command)
			CMD_FORWARD: begin
				if (ev.toward_car)
					m.car_total = m.car_total + 32'd1;
				else
					m.phone_total = m.phone_total + 32'd1;
			end
			CMD_FAILURE: begin
				if (ev.error_code == m.err_code) begin
					m.err_run = m.err_run + 32'd1;
				end else begin
					m.err_code = ev.error_code;
					m.err_run = 32'd1;
				end
				m.fail_ms = ev.time_ms;
			end
			CMD_SET_UDP: m.udp = ev.slots_used;
			CMD_SET_TCP: m.tcp = ev.slots_used;
			CMD_SAMPLE: begin
				// wrap-safe elapsed time; zero elapsed keeps rates and marks
				elapsed = ev.time_ms - m.mark_ms;
				if (elapsed != 32'd0) begin
					m.car_rate = pps_tenths(m.car_total - m.car_mark, elapsed);
					m.phone_rate = pps_tenths(m.phone_total - m.phone_mark, elapsed);
					m.car_mark = m.car_total;
					m.phone_mark = m.phone_total;
					m.mark_ms = ev.time_ms;
				end
			end
			default: ;
		endcase
		s.packets_to_car = m.car_total;
		s.packets_to_phone = m.phone_total;
		s.rate_to_car = m.car_rate;
		s.rate_to_phone = m.phone_rate;
		s.last_error = m.err_code;
		s.error_run = m.err_run;
		s.last_failure_ms = m.fail_ms;
		s.udp_in_use = m.udp;
		s.tcp_in_use = m.tcp;
		return s;
	endfunction

	function automatic event_t ev_of(logic [2:0] cmd, logic car, logic [31:0] code,
		logic [31:0] ms, logic [7:0] slots);
		event_t ev;
		ev.command = cmd;
		ev.toward_car = car;
		ev.error_code = code;
		ev.time_ms = ms;
		ev.slots_used = slots;
		return ev;
	endfunction

	function automatic snapshot_t snap_of(logic [31:0] car, logic [31:0] phone,
		logic [15:0] rc, logic [15:0] rp, logic [31:0] err, logic [31:0] run,
		logic [31:0] fms, logic [7:0] udp, logic [7:0] tcp);
		snapshot_t s;
		s.packets_to_car = car;
		s.packets_to_phone = phone;
		s.rate_to_car = rc;
		s.rate_to_phone = rp;
		s.last_error = err;
		s.error_run = run;
		s.last_failure_ms = fms;
		s.udp_in_use = udp;
		s.tcp_in_use = tcp;
		return s;
	endfunction

	function automatic string snap_str(snapshot_t s);
		return $sformatf({"car=%0d phone=%0d rate_car=%0d rate_phone=%0d err=%0d run=%0d ",
			"fail_ms=%0d udp=%0d tcp=%0d"}, s.packets_to_car, s.packets_to_phone,
			s.rate_to_car, s.rate_to_phone, s.last_error, s.error_run, s.last_failure_ms,
			s.udp_in_use, s.tcp_in_use);
	endfunction

	function automatic bit snap_differs(snapshot_t a, snapshot_t b);
		return (a.packets_to_car !== b.packets_to_car) ||
			(a.packets_to_phone !== b.packets_to_phone) ||
			(a.rate_to_car !== b.rate_to_car) ||
			(a.rate_to_phone !== b.rate_to_phone) ||
			(a.last_error !== b.last_error) ||
			(a.error_run !== b.error_run) ||
			(a.last_failure_ms !== b.last_failure_ms) ||
			(a.udp_in_use !== b.udp_in_use) ||
			(a.tcp_in_use !== b.tcp_in_use);
	endfunction

	// Present one event and hold it until the block takes it
	task automatic offer(input event_t ev, input bit typed, input snapshot_t typed_snap);
		snapshot_t predicted;
		evt_if.valid <= 1'b1;
		evt_if.command <= ev.command;
		evt_if.toward_car <= ev.toward_car;
		evt_if.error_code <= ev.error_code;
		evt_if.time_ms <= ev.time_ms;
		evt_if.slots_used <= ev.slots_used;
		@(posedge clk);
		while (!evt_if.ready) @(posedge clk);
		if (ev.command == CMD_SAMPLE) begin
			sample_events++;
			if (ev.time_ms == meter.mark_ms)
				idle_samples++;
		end
		if (ev.command == CMD_FAILURE)
			failure_events++;
		predicted = meter_step(meter, ev);
		pending_snaps.push_back(typed ? typed_snap : predicted);
		accepted_events++;
	endtask

	// Sender pacing: bursts of items with idle gaps, none in the steady window
	task automatic pace();
		if (accepted_events >= STEADY_FIRST && accepted_events < STEADY_LAST)
			return;
		if (burst_left == 0) begin
			evt_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end else begin
			burst_left--;
		end
	endtask

	// Snapshot checker
	always @(posedge clk) begin : stats_check
		snapshot_t got;
		snapshot_t want;
		if (arst_n && stats_if.valid && stats_if.ready) begin
			got.packets_to_car = stats_if.packets_to_car;
			got.packets_to_phone = stats_if.packets_to_phone;
			got.rate_to_car = stats_if.rate_to_car;
			got.rate_to_phone = stats_if.rate_to_phone;
			got.last_error = stats_if.last_error;
			got.error_run = stats_if.error_run;
			got.last_failure_ms = stats_if.last_failure_ms;
			got.udp_in_use = stats_if.udp_in_use;
			got.tcp_in_use = stats_if.tcp_in_use;
			if (pending_snaps.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR %0t: snapshot with no event pending: %s", $time,
						snap_str(got));
			end else begin
				want = pending_snaps.pop_front();
				snaps_checked++;
				if (snap_differs(want, got)) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("ERROR %0t: snapshot mismatch", $time);
						$display("  expected %s", snap_str(want));
						$display("  actual   %s", snap_str(got));
					end
				end
			end
		end
	end

	// Receiver: switches between stall patterns, plus one long hold-off
	initial begin : stats_drain
		int unsigned mode;
		int unsigned mode_left;
		int unsigned phase;
		stats_if.ready = 1'b0;
		mode = 0;
		mode_left = 0;
		phase = 0;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_seen && accepted_events >= HOLD_AT) begin
				hold_seen = 1'b1;
				stats_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 400);
			end
			mode_left--;
			phase++;
			case (mode)
				0: stats_if.ready <= 1'b1;
				1: stats_if.ready <= ($urandom_range(0, 99) < 55);
				default: stats_if.ready <= ((phase % 7) < 4);
			endcase
		end
	end

	// Run limit
	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("ERROR: run limit of %0d cycles reached", CYCLE_LIMIT);
		$display("relay_traffic_rate_monitor regression: fail");
		$finish;
	end

	// Stimulus and end of run
	initial begin : stimulus
		dir_row_t    rows[$];
		event_t      ev;
		snapshot_t   none;
		int unsigned pick;
		logic [31:0] now_ms;

		none = '{default: '0};
		meter = '{default: '0};
		mismatches = 0;
		snaps_checked = 0;
		accepted_events = 0;
		sample_events = 0;
		idle_samples = 0;
		failure_events = 0;
		burst_left = 0;
		now_ms = 32'd3;
		evt_if.valid = 1'b0;
		evt_if.command = CMD_FORWARD;
		evt_if.toward_car = 1'b0;
		evt_if.error_code = '0;
		evt_if.time_ms = '0;
		evt_if.slots_used = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Slot extremes straight after reset
		rows.push_back('{ev_of(CMD_SET_UDP, 1'b1, 32'h1234, 32'h55, 8'hFF), 1'b1,
			snap_of(0, 0, 0, 0, 0, 0, 0, 8'hFF, 8'h00)});
		rows.push_back('{ev_of(CMD_SET_TCP, 1'b0, 32'hAAAA_5555, 32'h0, 8'hFF), 1'b1,
			snap_of(0, 0, 0, 0, 0, 0, 0, 8'hFF, 8'hFF)});
		rows.push_back('{ev_of(CMD_SET_UDP, 1'b0, 32'h0, 32'hFFFF_FFFF, 8'h00), 1'b1,
			snap_of(0, 0, 0, 0, 0, 0, 0, 8'h00, 8'hFF)});
		// First failure with code zero is a repeat of the reset code
		rows.push_back('{ev_of(CMD_FAILURE, 1'b1, 32'h0, 32'hFFFF_FFFF, 8'h07), 1'b1,
			snap_of(0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, 8'h00, 8'hFF)});
		rows.push_back('{ev_of(CMD_FAILURE, 1'b0, 32'h0, 32'h0, 8'h00), 1'b1,
			snap_of(0, 0, 0, 0, 0, 2, 0, 8'h00, 8'hFF)});
		rows.push_back('{ev_of(CMD_FAILURE, 1'b0, 32'h8000_0000, 32'd7, 8'h00), 1'b1,
			snap_of(0, 0, 0, 0, 32'h8000_0000, 1, 7, 8'h00, 8'hFF)});
		rows.push_back('{ev_of(CMD_FAILURE, 1'b1, 32'h7FFF_FFFF, 32'd8, 8'hFF), 1'b1,
			snap_of(0, 0, 0, 0, 32'h7FFF_FFFF, 1, 8, 8'h00, 8'hFF)});
		// Spare commands and a sample with zero elapsed time change nothing
		rows.push_back('{ev_of(CMD_SPARE5, 1'b1, 32'd1, 32'h100, 8'h11), 1'b1,
			snap_of(0, 0, 0, 0, 32'h7FFF_FFFF, 1, 8, 8'h00, 8'hFF)});
		rows.push_back('{ev_of(CMD_SPARE7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF), 1'b1,
			snap_of(0, 0, 0, 0, 32'h7FFF_FFFF, 1, 8, 8'h00, 8'hFF)});
		rows.push_back('{ev_of(CMD_SAMPLE, 1'b1, 32'd5, 32'd0, 8'hFF), 1'b1,
			snap_of(0, 0, 0, 0, 32'h7FFF_FFFF, 1, 8, 8'h00, 8'hFF)});
		// Forwarded packets in both directions
		for (int i = 1; i <= 3; i++)
			rows.push_back('{ev_of(CMD_FORWARD, 1'b1, 32'd9, 32'd9, 8'h00), 1'b1,
				snap_of(i, 0, 0, 0, 32'h7FFF_FFFF, 1, 8, 8'h00, 8'hFF)});
		rows.push_back('{ev_of(CMD_FORWARD, 1'b0, 32'd9, 32'd9, 8'h00), 1'b1,
			snap_of(3, 1, 0, 0, 32'h7FFF_FFFF, 1, 8, 8'h00, 8'hFF)});
		rows.push_back('{ev_of(CMD_SAMPLE, 1'b0, 32'd0, 32'd1, 8'h00), 1'b0, none});
		// Rate overflow: seven packets in one millisecond
		for (int i = 0; i < 7; i++)
			rows.push_back('{ev_of(CMD_FORWARD, 1'b1, 32'd0, 32'd0, 8'h00), 1'b0, none});
		rows.push_back('{ev_of(CMD_SAMPLE, 1'b0, 32'd0, 32'd2, 8'h00), 1'b0, none});
		// Time wrap across the top of the millisecond counter
		rows.push_back('{ev_of(CMD_SAMPLE, 1'b1, 32'd0, 32'hFFFF_FFFF, 8'h00), 1'b0, none});
		rows.push_back('{ev_of(CMD_FORWARD, 1'b0, 32'd0, 32'd0, 8'h00), 1'b0, none});
		rows.push_back('{ev_of(CMD_SAMPLE, 1'b0, 32'd0, 32'd3, 8'h00), 1'b0, none});

		foreach (rows[i]) begin
			offer(rows[i].ev, rows[i].typed, rows[i].snap);
			pace();
		end

		// Random traffic: mostly forwards and samples with plausible timing
		for (int n = 0; n < RANDOM_EVENTS; n++) begin
			ev = ev_of(CMD_SPARE5, 1'($urandom_range(0, 1)), $urandom, $urandom,
				8'($urandom_range(0, 255)));
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				ev.command = CMD_FORWARD;
			end else if (pick < 60) begin
				ev.command = CMD_FAILURE;
				if ($urandom_range(0, 1))
					ev.time_ms = now_ms;
				case ($urandom_range(0, 3))
					0, 1: ev.error_code = meter.err_code;
					2: ev.error_code = 32'($urandom_range(0, 3)) - 32'd1;
					default: ;
				endcase
			end else if (pick < 66) begin
				ev.command = CMD_SET_UDP;
			end else if (pick < 72) begin
				ev.command = CMD_SET_TCP;
			end else if (pick < 95) begin
				ev.command = CMD_SAMPLE;
				pick = $urandom_range(0, 19);
				if (pick < 2) begin
					ev.time_ms = meter.mark_ms;
				end else if (pick == 2) begin
					now_ms = ev.time_ms;
				end else begin
					if (pick < 7)
						now_ms = now_ms + $urandom_range(1, 4);
					else
						now_ms = now_ms + $urandom_range(5, 3000);
					ev.time_ms = now_ms;
				end
			end else begin
				ev.command = 3'($urandom_range(5, 7));
			end
			offer(ev, 1'b0, none);
			if (n != RANDOM_EVENTS - 1)
				pace();
		end
		evt_if.valid <= 1'b0;

		while (pending_snaps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d events: %0d samples (%0d with no elapsed time), %0d failures.",
			accepted_events, sample_events, idle_samples, failure_events);
		$display("Checked %0d snapshots, long receiver hold-off %0s, %0d mismatches.",
			snaps_checked, hold_seen ? "applied" : "not reached", mismatches);
		if (mismatches == 0)
			$display("relay_traffic_rate_monitor regression: pass");
		else
			$display("relay_traffic_rate_monitor regression: fail");
		$finish;
	end

endmodule
